FILE: rtl/srpl_pkg.sv
// ----------------------------------------------------------------------------
// srpl_pkg
// Types, codes and helpers shared by the S-record character parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srpl_pkg;

  localparam int AddrBits = 16;

  localparam logic [7:0] ChS    = 8'h53;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChUA   = 8'h41;
  localparam logic [7:0] ChUF   = 8'h46;
  localparam logic [7:0] ChLA   = 8'h61;
  localparam logic [7:0] ChLF   = 8'h66;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] MinLen = 8'd3;
  localparam logic [7:0] SumOk  = 8'hFF;

  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_TYPE = 4'd1,
    PH_LEN  = 4'd2,
    PH_AHI  = 4'd3,
    PH_ALO  = 4'd4,
    PH_DATA = 4'd5,
    PH_CHK  = 4'd6,
    PH_HUNT = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TGT_PROGRAM  = 2'd0,
    TGT_DATA     = 2'd1,
    TGT_REGISTER = 2'd2
  } target_t;

  typedef enum logic [2:0] {
    ERR_MISSING_S = 3'd0,
    ERR_BAD_TYPE  = 3'd1,
    ERR_CHECKSUM  = 3'd2,
    ERR_BAD_HEX   = 3'd3,
    ERR_SHORT_LEN = 3'd4
  } error_t;

  localparam logic [3:0] TypeProgram  = 4'd1;
  localparam logic [3:0] TypeData     = 4'd2;
  localparam logic [3:0] TypeRegister = 4'd3;

  typedef struct packed {
    phase_t               phase;
    logic [3:0]           high_nibble;
    logic                 nibble_pending;
    logic [3:0]           type_digit;
    logic [7:0]           bytes_left;
    logic [7:0]           byte_index;
    logic [AddrBits-1:0]  base_address;
    logic [7:0]           running_sum;
  } parse_state_t;

  typedef struct packed {
    kind_t                kind;
    target_t              target;
    logic [AddrBits-1:0]  write_address;
    logic [7:0]           write_byte;
    logic [3:0]           record_type;
    error_t               error_code;
  } result_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    hex_decode = 5'd0;
    if (c >= Ch0 && c <= Ch9) begin
      d = c - Ch0;
      hex_decode = {1'b1, d[3:0]};
    end else if (c >= ChUA && c <= ChUF) begin
      d = c - ChUA + 8'd10;
      hex_decode = {1'b1, d[3:0]};
    end else if (c >= ChLA && c <= ChLF) begin
      d = c - ChLA + 8'd10;
      hex_decode = {1'b1, d[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/srpl_step.sv
// ----------------------------------------------------------------------------
// srpl_step
// Next-state and result logic for one character of the S-record stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpl_step (
  input  var srpl_pkg::parse_state_t state_i,
  input  var logic [7:0]             char_i,
  output srpl_pkg::parse_state_t     state_o,
  output logic                       res_valid_o,
  output srpl_pkg::result_t          res_o
);

  logic [4:0]                     hex;
  logic [7:0]                     byte_val;
  logic [7:0]                     sum_nxt;
  logic [7:0]                     left_nxt;
  logic [7:0]                     type_diff;
  logic [srpl_pkg::AddrBits-1:0]  data_addr;

  always_comb begin
    hex       = srpl_pkg::hex_decode(char_i);
    byte_val  = {state_i.high_nibble, hex[3:0]};
    sum_nxt   = state_i.running_sum + byte_val;
    left_nxt  = state_i.bytes_left - 8'd1;
    type_diff = char_i - srpl_pkg::Ch0;
    data_addr = state_i.base_address
              + {{(srpl_pkg::AddrBits-8){1'b0}}, state_i.byte_index};

    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_i.phase)
      srpl_pkg::PH_WAIT, srpl_pkg::PH_HUNT: begin
        if (char_i == srpl_pkg::ChS) begin
          state_o       = '0;
          state_o.phase = srpl_pkg::PH_TYPE;
        end else if (state_i.phase == srpl_pkg::PH_WAIT &&
                     char_i != srpl_pkg::ChCr && char_i != srpl_pkg::ChLf) begin
          res_valid_o          = 1'b1;
          res_o.kind           = srpl_pkg::KIND_ERROR;
          res_o.error_code     = srpl_pkg::ERR_MISSING_S;
          state_o.phase        = srpl_pkg::PH_HUNT;
          state_o.nibble_pending = 1'b0;
        end
      end
      srpl_pkg::PH_TYPE: begin
        if (char_i < srpl_pkg::Ch0 || char_i > srpl_pkg::Ch9) begin
          res_valid_o            = 1'b1;
          res_o.kind             = srpl_pkg::KIND_ERROR;
          res_o.error_code       = srpl_pkg::ERR_BAD_TYPE;
          state_o.phase          = srpl_pkg::PH_HUNT;
          state_o.nibble_pending = 1'b0;
        end else begin
          state_o.type_digit = type_diff[3:0];
          state_o.phase      = srpl_pkg::PH_LEN;
        end
      end
      srpl_pkg::PH_LEN, srpl_pkg::PH_AHI, srpl_pkg::PH_ALO,
      srpl_pkg::PH_DATA, srpl_pkg::PH_CHK: begin
        res_o.record_type = state_i.type_digit;
        if (!hex[4]) begin
          res_valid_o            = 1'b1;
          res_o.kind             = srpl_pkg::KIND_ERROR;
          res_o.error_code       = srpl_pkg::ERR_BAD_HEX;
          state_o.phase          = srpl_pkg::PH_HUNT;
          state_o.nibble_pending = 1'b0;
        end else if (!state_i.nibble_pending) begin
          state_o.high_nibble    = hex[3:0];
          state_o.nibble_pending = 1'b1;
        end else begin
          state_o.nibble_pending = 1'b0;
          state_o.running_sum    = sum_nxt;
          unique case (state_i.phase)
            srpl_pkg::PH_LEN: begin
              if (byte_val < srpl_pkg::MinLen) begin
                res_valid_o      = 1'b1;
                res_o.kind       = srpl_pkg::KIND_ERROR;
                res_o.error_code = srpl_pkg::ERR_SHORT_LEN;
                state_o.phase    = srpl_pkg::PH_HUNT;
              end else begin
                state_o.bytes_left = byte_val - srpl_pkg::MinLen;
                state_o.phase      = srpl_pkg::PH_AHI;
              end
            end
            srpl_pkg::PH_AHI: begin
              state_o.base_address = {byte_val, 8'h00};
              state_o.phase        = srpl_pkg::PH_ALO;
            end
            srpl_pkg::PH_ALO: begin
              state_o.base_address = {state_i.base_address[15:8], byte_val};
              state_o.phase = (state_i.bytes_left != 8'd0) ? srpl_pkg::PH_DATA
                                                           : srpl_pkg::PH_CHK;
            end
            srpl_pkg::PH_DATA: begin
              res_o.write_byte = byte_val;
              if (state_i.type_digit == srpl_pkg::TypeProgram) begin
                res_valid_o         = 1'b1;
                res_o.target        = srpl_pkg::TGT_PROGRAM;
                res_o.write_address = data_addr;
              end else if (state_i.type_digit == srpl_pkg::TypeData) begin
                res_valid_o         = 1'b1;
                res_o.target        = srpl_pkg::TGT_DATA;
                res_o.write_address = data_addr;
              end else if (state_i.type_digit == srpl_pkg::TypeRegister) begin
                res_valid_o         = 1'b1;
                res_o.target        = srpl_pkg::TGT_REGISTER;
                res_o.write_address = {{(srpl_pkg::AddrBits-8){1'b0}},
                                       state_i.base_address[7:0]};
              end
              res_o.kind         = srpl_pkg::KIND_WRITE;
              state_o.byte_index = state_i.byte_index + 8'd1;
              state_o.bytes_left = left_nxt;
              if (left_nxt == 8'd0) begin
                state_o.phase = srpl_pkg::PH_CHK;
              end
            end
            default: begin
              res_valid_o   = 1'b1;
              state_o.phase = srpl_pkg::PH_WAIT;
              if (sum_nxt == srpl_pkg::SumOk) begin
                res_o.kind = srpl_pkg::KIND_ACCEPT;
              end else begin
                res_o.kind       = srpl_pkg::KIND_ERROR;
                res_o.error_code = srpl_pkg::ERR_CHECKSUM;
              end
            end
          endcase
        end
      end
      default: begin
        state_o.phase = srpl_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/srecord_char_parser_loader_core.sv
// ----------------------------------------------------------------------------
// srecord_char_parser_loader_core
// S-record character parser: decodes records and emits memory writes and
// record status.
// ----------------------------------------------------------------------------
//   channel | ports                                   | direction
//   in      | in_valid, in_stall, in_char_in          | character in
//   out     | out_valid, out_stall, out_kind, ...     | result out
//
// One character per cycle sustained unless a result stall holds the input;
// each result passes through the input register, then the result register.
// The parse state updates as the character leaves the input register.
// Reset (rst_n low, synchronous) empties both registers and waits for 'S'.
// A stall on the result side holds the input register only when the waiting
// character produces a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srecord_char_parser_loader_core (
  input  var logic                                clk,
  input  var logic                                rst_n,
  input  var logic                                in_valid,
  output logic                                    in_stall,
  input  var logic [7:0]                          in_char_in,
  output logic                                    out_valid,
  input  var logic                                out_stall,
  output logic [1:0]                              out_kind,
  output logic [1:0]                              out_target,
  output logic [srpl_pkg::AddrBits-1:0]           out_write_address,
  output logic [7:0]                              out_write_byte,
  output logic [3:0]                              out_record_type,
  output logic [2:0]                              out_error_code
);

  logic                    char_valid_r;
  logic [7:0]              char_r;
  srpl_pkg::parse_state_t  state_r;
  srpl_pkg::parse_state_t  state_nxt;
  logic                    res_valid;
  srpl_pkg::result_t       res;
  logic                    out_valid_r;
  srpl_pkg::result_t       out_r;
  logic                    out_free;
  logic                    advance;
  logic                    in_xfer;

  srpl_step u_step (
    .state_i     (state_r),
    .char_i      (char_r),
    .state_o     (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = char_valid_r && (!res_valid || out_free);
  assign in_stall = char_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_xfer) begin
        char_valid_r <= 1'b1;
      end else if (advance) begin
        char_valid_r <= 1'b0;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_char_in;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_target        = out_r.target;
  assign out_write_address = out_r.write_address;
  assign out_write_byte    = out_r.write_byte;
  assign out_record_type   = out_r.record_type;
  assign out_error_code    = out_r.error_code;

endmodule

`default_nettype wire

FILE: tb/sv/srpl_result_checker.sv
// ----------------------------------------------------------------------------
// srpl_result_checker
// Watches both channels of the S-record parser, predicts the result of every
// transferred character and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srpl_result_checker
  import srpl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_char_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          out_kind,
  input  logic [1:0]          out_target,
  input  logic [AddrBits-1:0] out_write_address,
  input  logic [7:0]          out_write_byte,
  input  logic [3:0]          out_record_type,
  input  logic [2:0]          out_error_code,
  output int unsigned         fail_count,
  output int unsigned         pending_count
);

  phase_t              rec_phase;
  logic [3:0]          hi_nib;
  logic                nib_held;
  logic [3:0]          rec_type;
  logic [7:0]          bytes_todo;
  logic [7:0]          data_idx;
  logic [AddrBits-1:0] load_base;
  logic [7:0]          byte_sum;

  result_t     expected_results[$];
  int unsigned mismatches = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic result_t make_result(input kind_t k, input target_t t,
                                          input logic [AddrBits-1:0] a,
                                          input logic [7:0] b,
                                          input logic [3:0] rt,
                                          input error_t e);
    result_t r;
    r.kind          = k;
    r.target        = t;
    r.write_address = a;
    r.write_byte    = b;
    r.record_type   = rt;
    r.error_code    = e;
    return r;
  endfunction

  task automatic clear_record();
    hi_nib     = 4'd0;
    nib_held   = 1'b0;
    rec_type   = 4'd0;
    bytes_todo = 8'd0;
    data_idx   = 8'd0;
    load_base  = '0;
    byte_sum   = 8'd0;
  endtask

  task automatic flag_error(input error_t e, input logic [3:0] rt, output result_t r);
    r         = make_result(KIND_ERROR, TGT_PROGRAM, '0, 8'd0, rt, e);
    rec_phase = PH_HUNT;
    nib_held  = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] c, output logic produced, output result_t r);
    logic                nib_ok;
    logic [3:0]          nib;
    logic [7:0]          b;
    logic [AddrBits-1:0] a;
    produced = 1'b0;
    r        = '0;
    nib_ok   = 1'b1;
    nib      = 4'd0;
    if (c >= Ch0 && c <= Ch9) begin
      nib = c[3:0];
    end else if ((c >= ChUA && c <= ChUF) || (c >= ChLA && c <= ChLF)) begin
      nib = c[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
    case (rec_phase)
      PH_WAIT: begin
        if (c == ChS) begin
          clear_record();
          rec_phase = PH_TYPE;
        end else if (c != ChCr && c != ChLf) begin
          flag_error(ERR_MISSING_S, 4'd0, r);
          produced = 1'b1;
        end
      end
      PH_HUNT: begin
        if (c == ChS) begin
          clear_record();
          rec_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (c < Ch0 || c > Ch9) begin
          flag_error(ERR_BAD_TYPE, 4'd0, r);
          produced = 1'b1;
        end else begin
          rec_type  = c[3:0];
          rec_phase = PH_LEN;
        end
      end
      default: begin
        if (!nib_ok) begin
          flag_error(ERR_BAD_HEX, rec_type, r);
          produced = 1'b1;
        end else if (!nib_held) begin
          hi_nib   = nib;
          nib_held = 1'b1;
        end else begin
          nib_held = 1'b0;
          b        = {hi_nib, nib};
          byte_sum = byte_sum + b;
          case (rec_phase)
            PH_LEN: begin
              if (b < MinLen) begin
                flag_error(ERR_SHORT_LEN, rec_type, r);
                produced = 1'b1;
              end else begin
                bytes_todo = b - MinLen;
                rec_phase  = PH_AHI;
              end
            end
            PH_AHI: begin
              load_base = {b, 8'h00};
              rec_phase = PH_ALO;
            end
            PH_ALO: begin
              load_base[7:0] = b;
              rec_phase      = (bytes_todo != 8'd0) ? PH_DATA : PH_CHK;
            end
            PH_DATA: begin
              a = load_base + {8'h00, data_idx};
              case (rec_type)
                TypeProgram: begin
                  r        = make_result(KIND_WRITE, TGT_PROGRAM, a, b, rec_type, ERR_MISSING_S);
                  produced = 1'b1;
                end
                TypeData: begin
                  r        = make_result(KIND_WRITE, TGT_DATA, a, b, rec_type, ERR_MISSING_S);
                  produced = 1'b1;
                end
                TypeRegister: begin
                  r        = make_result(KIND_WRITE, TGT_REGISTER, {8'h00, load_base[7:0]}, b,
                                         rec_type, ERR_MISSING_S);
                  produced = 1'b1;
                end
                default: ;
              endcase
              data_idx   = data_idx + 8'd1;
              bytes_todo = bytes_todo - 8'd1;
              if (bytes_todo == 8'd0) rec_phase = PH_CHK;
            end
            default: begin
              rec_phase = PH_WAIT;
              if (byte_sum == SumOk) begin
                r = make_result(KIND_ACCEPT, TGT_PROGRAM, '0, 8'd0, rec_type, ERR_MISSING_S);
              end else begin
                r = make_result(KIND_ERROR, TGT_PROGRAM, '0, 8'd0, rec_type, ERR_CHECKSUM);
              end
              produced = 1'b1;
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [AddrBits-1:0] want,
                             input logic [AddrBits-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    logic    produced;
    if (!rst_n) begin
      rec_phase = PH_WAIT;
      clear_record();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_target, out_write_address, out_write_byte, out_record_type,
               out_error_code};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, expected none actual %0h",
                   $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("target", want.target, got.target);
          check_field("write_address", want.write_address, got.write_address);
          check_field("write_byte", want.write_byte, got.write_byte);
          check_field("record_type", want.record_type, got.record_type);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      if (in_valid && !in_stall) begin
        parse_char(in_char_in, produced, want);
        if (produced) expected_results.push_back(want);
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb_srecord_char_parser_loader_core.sv
// ----------------------------------------------------------------------------
// tb_srecord_char_parser_loader_core
// Feeds the S-record parser directed and random character streams of valid,
// corrupted and noisy records under varying sender gaps and receiver stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_srecord_char_parser_loader_core;
  import srpl_pkg::*;

  localparam int RandomChars = 1300;
  localparam int HoldCycles  = 300;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [7:0]          in_char_in = 8'h00;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [1:0]          out_kind;
  logic [1:0]          out_target;
  logic [AddrBits-1:0] out_write_address;
  logic [7:0]          out_write_byte;
  logic [3:0]          out_record_type;
  logic [2:0]          out_error_code;
  int unsigned         fail_count;
  int unsigned         pending_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int chars_sent    = 0;
  bit hold_request  = 1'b0;

  always #5 clk = ~clk;

  srecord_char_parser_loader_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_target        (out_target),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_record_type   (out_record_type),
    .out_error_code    (out_error_code)
  );

  srpl_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_target        (out_target),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_record_type   (out_record_type),
    .out_error_code    (out_error_code),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return Ch0 + {4'h0, n};
    return ($urandom_range(1) ? ChLA : ChUA) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] pick_outside(input bit digits_only);
    logic [7:0] c;
    do begin
      c = $urandom_range(255);
    end while ((c >= Ch0 && c <= Ch9) ||
               (!digits_only && ((c >= ChUA && c <= ChUF) || (c >= ChLA && c <= ChLF))));
    return c;
  endfunction

  task automatic send_record(input logic [3:0] rtype, input logic [AddrBits-1:0] addr,
                             input logic [7:0] len, input bit bad_sum, input bit broken);
    logic [7:0] bytes[$];
    logic [7:0] text[$];
    logic [7:0] sum;
    int         ndata;
    int         pos;
    ndata = (len >= MinLen) ? len - MinLen : 0;
    bytes.push_back(len);
    bytes.push_back(addr[15:8]);
    bytes.push_back(addr[7:0]);
    for (int i = 0; i < ndata; i++) bytes.push_back($urandom_range(255));
    sum = 8'd0;
    foreach (bytes[i]) sum += bytes[i];
    sum = ~sum;
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    bytes.push_back(sum);
    text.push_back(ChS);
    text.push_back(Ch0 + {4'h0, rtype});
    foreach (bytes[i]) begin
      text.push_back(hex_char(bytes[i][7:4]));
      text.push_back(hex_char(bytes[i][3:0]));
    end
    if (broken) begin
      pos       = $urandom_range(1, text.size() - 1);
      text[pos] = pick_outside(pos == 1);
    end
    foreach (text[i]) send_char(text[i]);
  endtask

  task automatic random_action();
    int                  r;
    logic [3:0]          rtype;
    logic [AddrBits-1:0] addr;
    logic [7:0]          len;
    r     = $urandom_range(99);
    rtype = ($urandom_range(99) < 75) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(9));
    case ($urandom_range(9))
      0, 1:    addr = 16'hFFFF - 16'($urandom_range(7));
      2:       addr = 16'h0000;
      default: addr = $urandom_range(65535);
    endcase
    case ($urandom_range(99))
      0:             len = 8'hFF;
      1, 2, 3, 4, 5: len = 8'($urandom_range(40)) + MinLen;
      default:       len = 8'($urandom_range(6)) + MinLen;
    endcase
    if (r < 70) begin
      send_record(rtype, addr, len, $urandom_range(99) < 15, 1'b0);
    end else if (r < 82) begin
      send_record(rtype, addr, len, 1'b0, 1'b1);
    end else if (r < 88) begin
      send_record(rtype, addr, 8'($urandom_range(2)), 1'b0, 1'b0);
    end else if (r < 96) begin
      repeat ($urandom_range(1, 4)) send_char($urandom_range(255));
    end else begin
      send_char($urandom_range(1) ? ChCr : ChLf);
    end
    case ($urandom_range(3))
      1:       send_string("\r\n");
      2:       send_char(ChLf);
      3:       send_char(ChCr);
      default: ;
    endcase
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (int k = 0; k < HoldCycles; k++) @(posedge clk);
        hold_request = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    int  base;
    bit  long_done;
    long_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(8'h00);
    send_char(8'hFF);
    send_string("S:");
    send_string("S102");
    send_string("S3G");
    send_string("S1030000FC\r\n");

    base = chars_sent;
    while (chars_sent < base + RandomChars) begin
      if (chars_sent < base + RandomChars / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 65;
      end else if (chars_sent < base + 2 * RandomChars / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 37;
        if (!long_done) begin
          long_done = 1'b1;
          send_record(TypeProgram, 16'hFFF0, 8'hFF, 1'b0, 1'b0);
        end
      end else begin
        if (send_idle_pct != 0) hold_request = 1'b1;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_action();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (hold_request || pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("srecord_char_parser_loader_core verification clean");
    end else begin
      $display("srecord_char_parser_loader_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("srecord_char_parser_loader_core verification failed");
    $finish;
  end

endmodule
